// ===== hdl/jse_pkg.sv =====
// Package for the JSON string escaper with UTF-8 check.
// Holds request/result payload types, the emit plan type and character constants.
// No dependencies.
`default_nettype none

package jse_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       string_end;
  } out_t;

  // Output program for one request: nrep copies of \ufffd, then lit_len literal bytes.
  typedef struct packed {
    logic [2:0]      nrep;
    logic [2:0]      lit_len;
    logic [5:0][7:0] lit;
    logic            last;
  } plan_t;

  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChU         = 8'h75;
  localparam logic [7:0] ChZero      = 8'h30;

  // "\ufffd", first character in the lowest byte
  localparam logic [5:0][7:0] Repl = {8'h64, 8'h66, 8'h66, 8'h66, 8'h75, 8'h5c};
  localparam int unsigned ReplLen = 6;

  localparam logic [20:0] MinCp2   = 21'h000080;
  localparam logic [20:0] MinCp3   = 21'h000800;
  localparam logic [20:0] MinCp4   = 21'h010000;
  localparam logic [20:0] MaxCp    = 21'h10ffff;
  localparam logic [20:0] SurrLo   = 21'h00d800;
  localparam logic [20:0] SurrHi   = 21'h00dfff;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h57 + {4'd0, nib};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/jse_plan.sv =====
// UTF-8 sequence tracker and escape planner.
// Holds the partial multibyte sequence and turns each accepted byte into an emit plan.
// Depends on jse_pkg.
`default_nettype none

module jse_plan (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire jse_pkg::in_t   in_data,
  output jse_pkg::plan_t      plan
);

  logic [7:0]  held_bytes [3];
  logic [1:0]  held_count;
  logic [2:0]  seq_length;
  logic [20:0] code_point_acc;

  logic [1:0]  held_count_next;
  logic [2:0]  seq_length_next;
  logic [20:0] code_point_acc_next;
  logic        wr_en;
  logic [1:0]  wr_idx;

  logic [7:0]      b;
  logic            is_cont;
  logic [20:0]     cp;
  logic [20:0]     minv;
  logic            cp_ok;
  logic [7:0]      esc;
  logic [5:0][7:0] f_lit;
  logic [2:0]      f_len;
  logic            f_lead;
  logic [2:0]      f_seq;
  logic [20:0]     f_acc;

  assign b       = in_data.in_byte;
  assign is_cont = (b[7:6] == 2'b10);
  assign cp      = {code_point_acc[14:0], b[5:0]};

  always_comb begin
    unique case (seq_length)
      3'd2:    minv = jse_pkg::MinCp2;
      3'd3:    minv = jse_pkg::MinCp3;
      default: minv = jse_pkg::MinCp4;
    endcase
    cp_ok = (cp >= minv) && (cp <= jse_pkg::MaxCp) &&
            !((cp >= jse_pkg::SurrLo) && (cp <= jse_pkg::SurrHi));
  end

  // Judge a byte with nothing held
  always_comb begin
    f_lit  = '0;
    f_len  = 3'd0;
    f_lead = 1'b0;
    f_seq  = 3'd0;
    f_acc  = '0;
    case (b)
      8'h22:   esc = 8'h22;
      8'h5c:   esc = 8'h5c;
      8'h0a:   esc = 8'h6e;
      8'h0d:   esc = 8'h72;
      8'h09:   esc = 8'h74;
      8'h08:   esc = 8'h62;
      8'h0c:   esc = 8'h66;
      default: esc = 8'h00;
    endcase
    if (esc != 8'h00) begin
      f_lit[0] = jse_pkg::ChBackslash;
      f_lit[1] = esc;
      f_len    = 3'd2;
    end else if (b < 8'h20) begin
      f_lit[0] = jse_pkg::ChBackslash;
      f_lit[1] = jse_pkg::ChU;
      f_lit[2] = jse_pkg::ChZero;
      f_lit[3] = jse_pkg::ChZero;
      f_lit[4] = jse_pkg::hex_digit(b[7:4]);
      f_lit[5] = jse_pkg::hex_digit(b[3:0]);
      f_len    = 3'd6;
    end else if (!b[7]) begin
      f_lit[0] = b;
      f_len    = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      f_lead = 1'b1;
      f_seq  = 3'd2;
      f_acc  = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      f_lead = 1'b1;
      f_seq  = 3'd3;
      f_acc  = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      f_lead = 1'b1;
      f_seq  = 3'd4;
      f_acc  = {18'd0, b[2:0]};
    end else begin
      f_lit = jse_pkg::Repl;
      f_len = 3'(jse_pkg::ReplLen);
    end
  end

  always_comb begin
    held_count_next     = held_count;
    seq_length_next     = seq_length;
    code_point_acc_next = code_point_acc;
    wr_en               = 1'b0;
    wr_idx              = 2'd0;
    plan                = '0;
    plan.last           = in_data.in_last;
    if ((held_count != 2'd0) && is_cont) begin
      if (({1'b0, held_count} + 3'd1) >= seq_length) begin
        held_count_next     = 2'd0;
        seq_length_next     = 3'd0;
        code_point_acc_next = '0;
        if (cp_ok) begin
          for (int k = 0; k < 3; k++) begin
            if (k < int'(held_count)) begin
              plan.lit[k] = held_bytes[k];
            end
          end
          plan.lit[{1'b0, held_count}] = b;
          plan.lit_len = {1'b0, held_count} + 3'd1;
        end else begin
          plan.nrep = {1'b0, held_count} + 3'd1;
        end
      end else begin
        wr_en               = 1'b1;
        wr_idx              = held_count;
        held_count_next     = held_count + 2'd1;
        code_point_acc_next = cp;
        if (in_data.in_last) begin
          plan.nrep           = {1'b0, held_count} + 3'd1;
          held_count_next     = 2'd0;
          seq_length_next     = 3'd0;
          code_point_acc_next = '0;
        end
      end
    end else begin
      plan.nrep    = {1'b0, held_count};
      plan.lit     = f_lit;
      plan.lit_len = f_len;
      held_count_next     = 2'd0;
      seq_length_next     = 3'd0;
      code_point_acc_next = '0;
      if (f_lead) begin
        if (in_data.in_last) begin
          plan.lit     = jse_pkg::Repl;
          plan.lit_len = 3'(jse_pkg::ReplLen);
        end else begin
          wr_en               = 1'b1;
          wr_idx              = 2'd0;
          held_count_next     = 2'd1;
          seq_length_next     = f_seq;
          code_point_acc_next = f_acc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count     <= 2'd0;
      seq_length     <= 3'd0;
      code_point_acc <= '0;
    end else if (accept) begin
      held_count     <= held_count_next;
      seq_length     <= seq_length_next;
      code_point_acc <= code_point_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      held_bytes[wr_idx] <= b;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/json_string_escape_utf8_check.sv =====
// Top level of the JSON string escaper with UTF-8 check.
// Instantiates jse_plan, holds the plan register, byte emitter and output register.
// Depends on jse_pkg and jse_plan.
`default_nettype none

// Takes one string byte per request and returns its JSON-escaped form, one byte
// per result, with run_end on the last byte of each request's output and
// string_end on the last byte of the string. UTF-8 sequences are held until
// complete and copied if valid; each byte of a bad or truncated sequence becomes
// \ufffd. A request yields 0 to 24 output bytes and holds the emitter until all are
// emitted; a request is taken in the same cycle its predecessor's final byte is
// emitted, so plain ASCII runs at one byte per cycle unless the result side stalls.
// A byte that is only held produces no result. The single output byte per cycle of
// the emitter sets the rate; the output register decouples the result side.
module json_string_escape_utf8_check (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire jse_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output jse_pkg::out_t      out_data
);

  jse_pkg::plan_t plan_next;
  logic           accept;

  logic [2:0]      rep_left;
  logic [2:0]      rep_pos;
  logic [2:0]      lit_pos;
  logic [2:0]      lit_len;
  logic [5:0][7:0] lit;
  logic            last;

  logic       busy;
  logic       adv;
  logic       final_byte;
  logic [7:0] cur_byte;

  jse_plan u_plan (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .plan    (plan_next)
  );

  assign busy = (rep_left != 3'd0) || (lit_pos != lit_len);
  assign adv  = busy && (!out_valid || out_ready);

  always_comb begin
    if (rep_left != 3'd0) begin
      cur_byte   = jse_pkg::Repl[rep_pos];
      final_byte = (rep_left == 3'd1) && (rep_pos == 3'(jse_pkg::ReplLen - 1)) &&
                   (lit_len == 3'd0);
    end else begin
      cur_byte   = lit[lit_pos];
      final_byte = ((lit_pos + 3'd1) == lit_len);
    end
  end

  assign in_ready = !rst && (!busy || (adv && final_byte));
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_left <= 3'd0;
      rep_pos  <= 3'd0;
      lit_pos  <= 3'd0;
      lit_len  <= 3'd0;
    end else if (accept) begin
      rep_left <= plan_next.nrep;
      rep_pos  <= 3'd0;
      lit_pos  <= 3'd0;
      lit_len  <= plan_next.lit_len;
    end else if (adv) begin
      if (rep_left != 3'd0) begin
        if (rep_pos == 3'(jse_pkg::ReplLen - 1)) begin
          rep_pos  <= 3'd0;
          rep_left <= rep_left - 3'd1;
        end else begin
          rep_pos <= rep_pos + 3'd1;
        end
      end else begin
        lit_pos <= lit_pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lit  <= plan_next.lit;
      last <= plan_next.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.out_byte   <= cur_byte;
      out_data.run_end    <= final_byte;
      out_data.string_end <= final_byte && last;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for json_string_escape_utf8_check: directed and random strings,
// with stalls on both sides. Expected bytes come from an in-bench escaper.
// Depends on jse_pkg and the json_string_escape_utf8_check RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int CycleLimit = 1_000_000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  jse_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  jse_pkg::out_t out_data;

  json_string_escape_utf8_check dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // escaper state
  logic [7:0]  held_byte [3];
  int          held_cnt = 0;
  int          seq_len = 0;
  logic [20:0] cp_acc = '0;

  jse_pkg::out_t step_bytes [$];
  jse_pkg::out_t escaped_q [$];
  jse_pkg::out_t want_r;
  logic [7:0]    str_q [$];

  int err_cnt = 0;
  int cycle_cnt = 0;
  int in_gap_max = 0;
  int out_gap_max = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void emit(input logic [7:0] b);
    jse_pkg::out_t r;
    r.out_byte = b;
    r.run_end = 1'b0;
    r.string_end = 1'b0;
    step_bytes.push_back(r);
  endfunction

  function automatic void emit_repl();
    emit("\\");
    emit("u");
    emit("f");
    emit("f");
    emit("f");
    emit("d");
  endfunction

  function automatic void flush_held();
    for (int k = 0; k < held_cnt; k++) emit_repl();
    held_cnt = 0;
    seq_len = 0;
    cp_acc = '0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? (8'h30 + 8'(nib)) : (8'h61 + 8'(nib) - 8'd10);
  endfunction

  function automatic void judge_fresh(input logic [7:0] b);
    logic [7:0] esc;
    case (b)
      8'h22: esc = 8'h22;
      8'h5c: esc = 8'h5c;
      8'h0a: esc = "n";
      8'h0d: esc = "r";
      8'h09: esc = "t";
      8'h08: esc = "b";
      8'h0c: esc = "f";
      default: esc = 8'h00;
    endcase
    if (esc != 8'h00) begin
      emit("\\");
      emit(esc);
    end else if (b < 8'h20) begin
      emit("\\");
      emit("u");
      emit("0");
      emit("0");
      emit(hex_char(b[7:4]));
      emit(hex_char(b[3:0]));
    end else if (b < 8'h80) begin
      emit(b);
    end else if (b[7:5] == 3'b110) begin
      held_byte[0] = b;
      held_cnt = 1;
      seq_len = 2;
      cp_acc = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      held_byte[0] = b;
      held_cnt = 1;
      seq_len = 3;
      cp_acc = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      held_byte[0] = b;
      held_cnt = 1;
      seq_len = 4;
      cp_acc = {18'd0, b[2:0]};
    end else begin
      emit_repl();
    end
  endfunction

  function automatic void escape_predict(input logic [7:0] b, input logic last);
    logic [20:0] cp;
    logic [20:0] minv;
    logic        ok;
    step_bytes.delete();
    if (held_cnt > 0) begin
      if (b[7:6] == 2'b10) begin
        cp = {cp_acc[14:0], b[5:0]};
        if (held_cnt + 1 >= seq_len) begin
          minv = (seq_len == 2) ? 21'h80 : (seq_len == 3) ? 21'h800 : 21'h10000;
          ok = cp >= minv && cp <= 21'h10ffff && !(cp >= 21'hd800 && cp <= 21'hdfff);
          if (ok) begin
            for (int k = 0; k < held_cnt; k++) emit(held_byte[k]);
            emit(b);
            held_cnt = 0;
            seq_len = 0;
            cp_acc = '0;
          end else begin
            held_cnt++;
            flush_held();
          end
        end else begin
          held_byte[held_cnt] = b;
          held_cnt++;
          cp_acc = cp;
        end
      end else begin
        flush_held();
        judge_fresh(b);
      end
    end else begin
      judge_fresh(b);
    end
    if (last && held_cnt > 0) flush_held();
    if (step_bytes.size() > 0) begin
      step_bytes[step_bytes.size() - 1].run_end = 1'b1;
      step_bytes[step_bytes.size() - 1].string_end = last;
    end
    foreach (step_bytes[i]) escaped_q.push_back(step_bytes[i]);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_req(input logic [7:0] b, input logic last);
    int gap;
    gap = (in_gap_max == 0) ? 0 : $urandom_range(in_gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {b, last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    escape_predict(b, last);
    @(negedge clk);
  endtask

  task automatic send_string();
    for (int i = 0; i < str_q.size(); i++) send_req(str_q[i], i == str_q.size() - 1);
  endtask

  function automatic void push_utf8(input logic [20:0] cp, input int len);
    case (len)
      2: str_q.push_back({3'b110, cp[10:6]});
      3: str_q.push_back({4'b1110, cp[15:12]});
      default: str_q.push_back({5'b11110, cp[20:18]});
    endcase
    for (int k = len - 2; k >= 0; k--) str_q.push_back({2'b10, cp[6*k +: 6]});
  endfunction

  task automatic test_ascii_escapes();
    in_gap_max = 0;
    out_gap_max = 0;
    str_q = '{8'h22, 8'h5c, 8'h0a, 8'h0d, 8'h09, 8'h08, 8'h0c, 8'h00, 8'h1f, 8'h20, 8'h7f};
    send_string();
  endtask

  // valid minimum, surrogate, above max, overlong, stray, bad lead,
  // interrupted sequence, and a string cut short inside a sequence
  task automatic test_utf8_sequences();
    in_gap_max = 17;
    out_gap_max = 17;
    str_q = '{8'hc2, 8'h80, 8'hed, 8'ha0, 8'h80, 8'hf4, 8'h90, 8'h80, 8'h80,
              8'hc0, 8'h80, 8'hbf, 8'hff, 8'he2, 8'h41, 8'hf0, 8'h9f};
    send_string();
  endtask

  task automatic test_random_strings(input int n_bytes);
    int          sent;
    int          kind;
    int          len;
    logic [20:0] cp;
    logic [20:0] lo;
    logic [20:0] hi;
    sent = 0;
    while (sent < n_bytes) begin
      case ($urandom_range(3, 0))
        0: begin in_gap_max = 0;  out_gap_max = 0;  end
        1: begin in_gap_max = 17; out_gap_max = 0;  end
        2: begin in_gap_max = 0;  out_gap_max = 17; end
        default: begin in_gap_max = 17; out_gap_max = 17; end
      endcase
      str_q.delete();
      repeat ($urandom_range(12, 1)) begin
        kind = $urandom_range(99, 0);
        len = $urandom_range(4, 2);
        if (kind < 35) begin
          str_q.push_back(8'($urandom_range(127, 0)));
        end else if (kind < 70) begin
          lo = (len == 2) ? 21'h80 : (len == 3) ? 21'h800 : 21'h10000;
          hi = (len == 2) ? 21'h7ff : (len == 3) ? 21'hffff : 21'h10ffff;
          if ($urandom_range(5, 0) == 0) cp = $urandom_range(1, 0) ? hi : lo;
          else cp = 21'($urandom_range(hi, lo));
          if (cp >= 21'hd800 && cp <= 21'hdfff) cp = cp ^ 21'h2000;
          push_utf8(cp, len);
        end else if (kind < 78) begin
          str_q.push_back(8'($urandom_range(255, 0)));
        end else if (kind < 88) begin
          // may be overlong, surrogate or above range
          hi = (len == 2) ? 21'h7ff : (len == 3) ? 21'hffff : 21'h1fffff;
          if (len == 3 && $urandom_range(1, 0) == 1) begin
            cp = 21'($urandom_range(21'hdfff, 21'hd800));
          end else begin
            cp = 21'($urandom_range(hi, 0));
          end
          push_utf8(cp, len);
        end else begin
          push_utf8(21'($urandom()), len);
          repeat ($urandom_range(len - 1, 1)) void'(str_q.pop_back());
        end
      end
      sent += str_q.size();
      send_string();
    end
  endtask

  task automatic note_mismatch(input string what, input jse_pkg::out_t want,
                               input jse_pkg::out_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display({"%0t: %s: expected byte %h run_end %b string_end %b, ",
                "got byte %h run_end %b string_end %b"},
               $realtime, what, want.out_byte, want.run_end, want.string_end,
               got.out_byte, got.run_end, got.string_end);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (escaped_q.size() == 0) begin
        note_mismatch("unexpected result", '0, out_data);
      end else begin
        want_r = escaped_q.pop_front();
        if (out_data.out_byte !== want_r.out_byte || out_data.run_end !== want_r.run_end ||
            out_data.string_end !== want_r.string_end) begin
          note_mismatch("mismatch", want_r, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : result_side
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = (out_gap_max == 0) ? 0 : $urandom_range(out_gap_max, 0);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_ascii_escapes();
    test_utf8_sequences();
    test_random_strings(330);
    in_valid <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
